### rtl/core/tsmu_pkg.sv
// Shared types and constants for the table state machine with undo.
package tsmu_pkg;

  // Item operation codes
  typedef enum logic [2:0] {
    OP_WRITE_NEXT = 3'd0,
    OP_WRITE_WIN  = 3'd1,
    OP_START      = 3'd2,
    OP_MOVE       = 3'd3,
    OP_UNDO       = 3'd4
  } op_e;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_FLAG,
    ST_UNDO
  } fsm_e;

  // Field widths of one transaction
  localparam int unsigned OP_W    = 3;
  localparam int unsigned STATE_W = 8;
  localparam int unsigned DIR_W   = 3;
  localparam int unsigned NEXT_W  = 16;
  localparam int unsigned DEPTH_W = 6;

  // Next-state code that marks a missing transition
  localparam logic [NEXT_W-1:0] NO_TRANSITION = 16'hFFFF;

  // Register port
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam int unsigned COUNT_W = 9;
  localparam logic [PADDR_W-3:0] REG_STATE_COUNT = '0;

endpackage

### rtl/core/tsmu_regs.sv
// APB configuration register block holding the valid state count.
module tsmu_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [tsmu_pkg::PADDR_W-1:0]       paddr,
  input  logic [tsmu_pkg::PDATA_W-1:0]       pwdata,
  output logic [tsmu_pkg::PDATA_W-1:0]       prdata,
  output logic                               pready,
  output logic [tsmu_pkg::COUNT_W-1:0]       state_count_o
);

  logic                         sel_count;
  logic                         wr_count;
  logic [tsmu_pkg::COUNT_W-1:0] state_count_q;

  // Address decode, word granular
  assign sel_count = (paddr[tsmu_pkg::PADDR_W-1:2] == tsmu_pkg::REG_STATE_COUNT);
  assign wr_count  = psel & penable & pwrite & sel_count;
  assign pready    = 1'b1;

  // State count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_count_q <= '0;
    end else if (wr_count) begin
      state_count_q <= pwdata[tsmu_pkg::COUNT_W-1:0];
    end
  end

  // Read mux
  always_comb begin
    if (sel_count) begin
      prdata = tsmu_pkg::PDATA_W'(state_count_q);
    end else begin
      prdata = '0;
    end
  end

  assign state_count_o = state_count_q;

endmodule

### rtl/core/table_state_machine_with_undo_core.sv
// Top level: table-driven state machine with a bounded undo history.
//
// Each transaction returns exactly one result. Table writes, win-flag writes,
// start, unused op codes, undos with nothing to pop and moves with an
// out-of-range direction finish from idle; an undo does one history read; a
// move ends in ST_LOOK if the stored target is rejected and in ST_FLAG if it
// is taken, since the next-state table read and the win-flag read that it
// addresses are chained through two memories with registered read data. One
// transaction is in flight at a time; a finished result sits in an output
// register, so the next transaction is taken once the sequencer is idle and
// that result is not stalled. The tables and the history hold garbage after
// reset and must be written before they are read; no clearing pass is run.
module table_state_machine_with_undo_core #(
  parameter int unsigned MAX_STATE_COUNT = 256,
  parameter int unsigned HISTORY_DEPTH   = 32,
  parameter int unsigned DIRECTION_COUNT = 5
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [tsmu_pkg::OP_W-1:0]           op_i,
  input  logic [tsmu_pkg::STATE_W-1:0]        entry_state_i,
  input  logic [tsmu_pkg::DIR_W-1:0]          direction_i,
  input  logic [tsmu_pkg::NEXT_W-1:0]         next_value_i,
  input  logic                                win_value_i,
  // output channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [tsmu_pkg::STATE_W-1:0]        current_state_o,
  output logic                                changed_o,
  output logic                                cleared_o,
  output logic [tsmu_pkg::DEPTH_W-1:0]        history_depth_o,
  // configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [tsmu_pkg::PADDR_W-1:0]        paddr,
  input  logic [tsmu_pkg::PDATA_W-1:0]        pwdata,
  output logic [tsmu_pkg::PDATA_W-1:0]        prdata,
  output logic                                pready
);

  localparam int unsigned SW         = $clog2(MAX_STATE_COUNT);
  localparam int unsigned TableDepth = MAX_STATE_COUNT * DIRECTION_COUNT;
  localparam int unsigned AW         = $clog2(TableDepth);
  localparam int unsigned HIW        = $clog2(HISTORY_DEPTH);
  localparam int unsigned TW         = $clog2(HISTORY_DEPTH + 1);
  localparam logic [tsmu_pkg::NEXT_W-1:0] MaxCount = 16'(MAX_STATE_COUNT);
  localparam logic [tsmu_pkg::DIR_W:0]    DirCount = 4'(DIRECTION_COUNT);
  localparam logic [TW-1:0]               HistFull = TW'(HISTORY_DEPTH);

  logic [tsmu_pkg::COUNT_W-1:0] state_count;

  // sequencer and architectural state
  tsmu_pkg::fsm_e  fsm_q, fsm_d;
  logic [SW-1:0]   present_q, present_d;
  logic [TW-1:0]   top_q, top_d;
  logic [SW-1:0]   target_q, target_d;

  // result register
  logic                          out_valid_q, out_valid_d;
  logic [tsmu_pkg::STATE_W-1:0]  out_state_q, out_state_d;
  logic                          out_changed_q, out_changed_d;
  logic                          out_cleared_q, out_cleared_d;
  logic [tsmu_pkg::DEPTH_W-1:0]  out_depth_q, out_depth_d;

  logic accept;
  logic load;
  logic changed;
  logic cleared;
  logic entry_ok;
  logic dir_ok;
  logic tgt_ok;

  // memories
  logic [tsmu_pkg::NEXT_W-1:0]  tbl_mem [TableDepth];
  logic                         tbl_we, tbl_re;
  logic [AW-1:0]                tbl_waddr, tbl_raddr;
  logic [tsmu_pkg::NEXT_W-1:0]  tbl_rdata_q;

  logic                         win_mem [MAX_STATE_COUNT];
  logic                         win_we, win_re;
  logic [SW-1:0]                win_waddr, win_raddr;
  logic                         win_rdata_q;

  logic [tsmu_pkg::STATE_W-1:0] hist_mem [HISTORY_DEPTH];
  logic                         hist_we, hist_re;
  logic [HIW-1:0]               hist_waddr, hist_raddr;
  logic [tsmu_pkg::STATE_W-1:0] hist_wdata;
  logic [tsmu_pkg::STATE_W-1:0] hist_rdata_q;

  // configuration register
  tsmu_regs u_regs (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .state_count_o (state_count)
  );

  // handshake
  assign in_stall_o = (fsm_q != tsmu_pkg::ST_IDLE) | (out_valid_q & out_stall_i);
  assign accept     = in_valid_i & ~in_stall_o;

  // range checks
  assign entry_ok = ({8'b0, entry_state_i} < MaxCount);
  assign dir_ok   = ({1'b0, direction_i} < DirCount);
  assign tgt_ok   = (tbl_rdata_q != tsmu_pkg::NO_TRANSITION) &&
                    (tbl_rdata_q < 16'(state_count)) &&
                    (tbl_rdata_q < MaxCount);

  // memory addresses
  assign tbl_waddr  = AW'(entry_state_i) * AW'(DIRECTION_COUNT) + AW'(direction_i);
  assign tbl_raddr  = AW'(present_q) * AW'(DIRECTION_COUNT) + AW'(direction_i);
  assign win_waddr  = SW'(entry_state_i);
  assign win_raddr  = SW'(tbl_rdata_q);
  assign hist_raddr = HIW'(top_q - TW'(2));

  // sequencer: next state, memory controls and result
  always_comb begin
    fsm_d      = fsm_q;
    present_d  = present_q;
    top_d      = top_q;
    target_d   = target_q;
    load       = 1'b0;
    changed    = 1'b0;
    cleared    = 1'b0;
    tbl_we     = 1'b0;
    tbl_re     = 1'b0;
    win_we     = 1'b0;
    win_re     = 1'b0;
    hist_we    = 1'b0;
    hist_re    = 1'b0;
    hist_waddr = '0;
    hist_wdata = '0;

    case (fsm_q)
      tsmu_pkg::ST_IDLE: begin
        if (accept) begin
          case (tsmu_pkg::op_e'(op_i))
            tsmu_pkg::OP_WRITE_NEXT: begin
              tbl_we = entry_ok & dir_ok;
              load   = 1'b1;
            end
            tsmu_pkg::OP_WRITE_WIN: begin
              win_we = entry_ok;
              load   = 1'b1;
            end
            tsmu_pkg::OP_START: begin
              present_d = '0;
              top_d     = TW'(1);
              hist_we   = 1'b1;
              load      = 1'b1;
            end
            tsmu_pkg::OP_MOVE: begin
              if (dir_ok) begin
                tbl_re = 1'b1;
                fsm_d  = tsmu_pkg::ST_LOOK;
              end else begin
                load = 1'b1;
              end
            end
            tsmu_pkg::OP_UNDO: begin
              if (top_q > TW'(1)) begin
                hist_re = 1'b1;
                fsm_d   = tsmu_pkg::ST_UNDO;
              end else begin
                load = 1'b1;
              end
            end
            default: begin
              load = 1'b1;
            end
          endcase
        end
      end
      // table entry is back: check target, fetch its win flag
      tsmu_pkg::ST_LOOK: begin
        if (tgt_ok) begin
          win_re   = 1'b1;
          target_d = SW'(tbl_rdata_q);
          fsm_d    = tsmu_pkg::ST_FLAG;
        end else begin
          load  = 1'b1;
          fsm_d = tsmu_pkg::ST_IDLE;
        end
      end
      // commit the move, push when there is room
      tsmu_pkg::ST_FLAG: begin
        present_d = target_q;
        changed   = 1'b1;
        cleared   = win_rdata_q;
        if (top_q < HistFull) begin
          hist_we    = 1'b1;
          hist_waddr = HIW'(top_q);
          hist_wdata = tsmu_pkg::STATE_W'(target_q);
          top_d      = top_q + TW'(1);
        end
        load  = 1'b1;
        fsm_d = tsmu_pkg::ST_IDLE;
      end
      // pop and restore the entry below the top
      tsmu_pkg::ST_UNDO: begin
        top_d     = top_q - TW'(1);
        present_d = SW'(hist_rdata_q);
        changed   = 1'b1;
        load      = 1'b1;
        fsm_d     = tsmu_pkg::ST_IDLE;
      end
      default: begin
        fsm_d = tsmu_pkg::ST_IDLE;
      end
    endcase
  end

  // result register next values
  always_comb begin
    out_valid_d   = out_valid_q & out_stall_i;
    out_state_d   = out_state_q;
    out_changed_d = out_changed_q;
    out_cleared_d = out_cleared_q;
    out_depth_d   = out_depth_q;
    if (load) begin
      out_valid_d   = 1'b1;
      out_state_d   = tsmu_pkg::STATE_W'(present_d);
      out_changed_d = changed;
      out_cleared_d = cleared;
      out_depth_d   = tsmu_pkg::DEPTH_W'(top_d);
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q       <= tsmu_pkg::ST_IDLE;
      present_q   <= '0;
      top_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      fsm_q       <= fsm_d;
      present_q   <= present_d;
      top_q       <= top_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    target_q      <= target_d;
    out_state_q   <= out_state_d;
    out_changed_q <= out_changed_d;
    out_cleared_q <= out_cleared_d;
    out_depth_q   <= out_depth_d;
  end

  // next-state table
  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      tbl_mem[tbl_waddr] <= next_value_i;
    end
    if (tbl_re) begin
      tbl_rdata_q <= tbl_mem[tbl_raddr];
    end
  end

  // win flags
  always_ff @(posedge clk_i) begin
    if (win_we) begin
      win_mem[win_waddr] <= win_value_i;
    end
    if (win_re) begin
      win_rdata_q <= win_mem[win_raddr];
    end
  end

  // undo history
  always_ff @(posedge clk_i) begin
    if (hist_we) begin
      hist_mem[hist_waddr] <= hist_wdata;
    end
    if (hist_re) begin
      hist_rdata_q <= hist_mem[hist_raddr];
    end
  end

  assign out_valid_o     = out_valid_q;
  assign current_state_o = out_state_q;
  assign changed_o       = out_changed_q;
  assign cleared_o       = out_cleared_q;
  assign history_depth_o = out_depth_q;

endmodule
